FILE: hw/rtl/frame_bitmap_run_allocator_core_defines.svh
// Assertion macros shared by the frame bitmap allocator RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef FRAME_BITMAP_RUN_ALLOCATOR_CORE_DEFINES_SVH
`define FRAME_BITMAP_RUN_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset only
`define FBRA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbra: same-cycle check failed");

// Next-cycle implication, checked out of reset only
`define FBRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbra: next-cycle check failed");

`endif

FILE: hw/rtl/fbra_pkg.sv
// Shared types and codes for the frame bitmap run allocator.
// No dependencies; used by frame_bitmap_run_allocator_core.
package fbra_pkg;

    localparam int WORD_BITS = 64;

    // Command codes
    localparam logic [1:0] CMD_FIND  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_USED  = 2'd2;
    localparam logic [1:0] CMD_FREE  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_RUN = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_ZERO   = 2'd3;

    typedef enum logic [6:0] {
        S_INIT     = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_MARK     = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_BYTE     = 7'b0010000,
        S_ALLOC_RD = 7'b0100000,
        S_ALLOC_WR = 7'b1000000
    } state_t;

endpackage

FILE: hw/rtl/fbra_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; contents are undefined until written.
module fbra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on request; the read data is registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/frame_bitmap_run_allocator_core.sv
// Top level of the first-fit page frame allocator over a usage bitmap.
// Depends on fbra_pkg, fbra_ram and frame_bitmap_run_allocator_core_defines.svh.
//
// One request is taken when start is high and busy is low; its single result
// shows on status and start_frame for exactly one cycle with done high, and
// the receiver cannot stall it. After reset a fill pass marks every frame
// used, with busy high. Mark commands read the bitmap word, then write it
// back. Find walks the bitmap words from word zero through the single read
// port, taking a wholly used or wholly free word whole and stepping a mixed
// word eight bits a cycle. Allocate then rewrites each word the run touches
// by read-modify-write. Errors (zero length, frame out of range) report in
// the cycle after the request is taken.

`include "frame_bitmap_run_allocator_core_defines.svh"

module frame_bitmap_run_allocator_core #(
    parameter int BITMAP_WORDS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [39:0] frame_index,
    input  logic [14:0] run_length,
    output logic        done,
    output logic [1:0]  status,
    output logic [13:0] start_frame
);

    import fbra_pkg::*;

    localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int FW = AW + 6;
    localparam logic [AW-1:0] LAST_WORD = AW'(BITMAP_WORDS - 1);

    state_t            state_reg, state_next;
    logic [AW-1:0]     word_reg, word_next;
    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [13:0]       start_frame_reg, start_frame_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [AW-1:0]     mark_word_reg, mark_word_next;
    logic [5:0]        mark_bit_reg, mark_bit_next;
    logic [14:0]       len_reg, len_next;
    logic [15:0]       have_reg, have_next;
    logic [FW-1:0]     first_reg, first_next;
    logic [2:0]        byte_reg, byte_next;
    logic [63:0]       data_reg, data_next;
    logic [FW-1:0]     start_reg, start_next;
    logic [FW-1:0]     end_reg, end_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [63:0]       ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [63:0]       ram_rdata;

    logic [15:0]       bs_have;
    logic [FW-1:0]     bs_first;
    logic              bs_found;
    logic [7:0]        bs_bits;

    logic [16:0]       have_plus;
    logic              word_fits;
    logic [FW-1:0]     run_first;
    logic [5:0]        mask_lo;
    logic [5:0]        mask_hi;
    logic [63:0]       alloc_mask;
    logic [63:0]       mark_bit;
    logic              found;
    logic [FW-1:0]     found_start;
    logic              advance;

    fbra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BITMAP_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Step one byte of a mixed word through the run counter
    always_comb
    begin
        bs_have  = have_reg;
        bs_first = first_reg;
        bs_found = 1'b0;
        bs_bits  = data_reg[{byte_reg, 3'b000} +: 8];
        for (int j = 0; j < 8; j++)
        begin
            if (!bs_found)
            begin
                if (bs_bits[j])
                begin
                    bs_have = '0;
                end
                else
                begin
                    if (bs_have == 16'd0)
                    begin
                        bs_first = {word_reg, byte_reg, 3'(j)};
                    end
                    bs_have = bs_have + 16'd1;
                    if (bs_have == {1'b0, len_reg})
                    begin
                        bs_found = 1'b1;
                    end
                end
            end
        end
    end

    // Whole-word shortcuts and write masks
    always_comb
    begin
        have_plus  = {1'b0, have_reg} + 17'd64;
        word_fits  = have_plus >= {2'b00, len_reg};
        run_first  = (have_reg == 16'd0) ? {word_reg, 6'd0} : first_reg;
        mask_lo    = (word_reg == start_reg[FW-1:6]) ? start_reg[5:0] : 6'd0;
        mask_hi    = (word_reg == end_reg[FW-1:6]) ? end_reg[5:0] : 6'd63;
        alloc_mask = ({64{1'b1}} << mask_lo) & ({64{1'b1}} >> (6'd63 - mask_hi));
        mark_bit   = 64'd1 << mark_bit_reg;
    end

    // Sequence commands over the bitmap memory
    always_comb
    begin
        state_next       = state_reg;
        word_next        = word_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        start_frame_next = start_frame_reg;
        cmd_next         = cmd_reg;
        mark_word_next   = mark_word_reg;
        mark_bit_next    = mark_bit_reg;
        len_next         = len_reg;
        have_next        = have_reg;
        first_next       = first_reg;
        byte_next        = byte_reg;
        data_next        = data_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        ram_we           = 1'b0;
        ram_waddr        = word_reg;
        ram_wdata        = ram_rdata;
        ram_raddr        = word_reg;
        found            = 1'b0;
        found_start      = run_first;
        advance          = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {64{1'b1}};
                if (word_reg == LAST_WORD)
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                ram_raddr = frame_index[AW+5:6];
                if (start)
                begin
                    cmd_next = cmd;
                    len_next = run_length;
                    if (cmd == CMD_USED || cmd == CMD_FREE)
                    begin
                        if (frame_index[39:6] >= 34'(BITMAP_WORDS))
                        begin
                            done_next        = 1'b1;
                            status_next      = ST_RANGE;
                            start_frame_next = '0;
                        end
                        else
                        begin
                            mark_word_next = frame_index[AW+5:6];
                            mark_bit_next  = frame_index[5:0];
                            state_next     = S_MARK;
                        end
                    end
                    else if (run_length == 15'd0)
                    begin
                        done_next        = 1'b1;
                        status_next      = ST_ZERO;
                        start_frame_next = '0;
                    end
                    else
                    begin
                        ram_raddr  = '0;
                        word_next  = '0;
                        have_next  = '0;
                        first_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_MARK:
            begin
                ram_we    = 1'b1;
                ram_waddr = mark_word_reg;
                ram_wdata = (cmd_reg == CMD_USED) ? (ram_rdata | mark_bit)
                                                  : (ram_rdata & ~mark_bit);
                done_next        = 1'b1;
                status_next      = ST_OK;
                start_frame_next = '0;
                state_next       = S_IDLE;
            end
            S_SCAN:
            begin
                if (&ram_rdata)
                begin
                    have_next = '0;
                    advance   = 1'b1;
                end
                else if (~|ram_rdata)
                begin
                    if (word_fits)
                    begin
                        found       = 1'b1;
                        found_start = run_first;
                    end
                    else
                    begin
                        have_next  = have_plus[15:0];
                        first_next = run_first;
                        advance    = 1'b1;
                    end
                end
                else
                begin
                    data_next  = ram_rdata;
                    byte_next  = '0;
                    state_next = S_BYTE;
                end
            end
            S_BYTE:
            begin
                have_next  = bs_have;
                first_next = bs_first;
                if (bs_found)
                begin
                    found       = 1'b1;
                    found_start = bs_first;
                end
                else if (byte_reg == 3'd7)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    byte_next = byte_reg + 3'd1;
                end
            end
            S_ALLOC_RD:
            begin
                ram_raddr  = start_reg[FW-1:6];
                word_next  = start_reg[FW-1:6];
                state_next = S_ALLOC_WR;
            end
            S_ALLOC_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | alloc_mask;
                if (word_reg == end_reg[FW-1:6])
                begin
                    done_next        = 1'b1;
                    status_next      = ST_OK;
                    start_frame_next = 14'(start_reg);
                    word_next        = '0;
                    state_next       = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + AW'(1);
                    ram_raddr = word_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Finish a successful search: report it or hand over to the rewrite
        if (found)
        begin
            if (cmd_reg == CMD_ALLOC)
            begin
                start_next = found_start;
                end_next   = found_start + FW'(len_reg) - FW'(1);
                state_next = S_ALLOC_RD;
            end
            else
            begin
                done_next        = 1'b1;
                status_next      = ST_OK;
                start_frame_next = 14'(found_start);
                word_next        = '0;
                state_next       = S_IDLE;
            end
        end

        // Move the scan to the next word, or give up at the end of the bitmap
        if (advance)
        begin
            if (word_reg == LAST_WORD)
            begin
                done_next        = 1'b1;
                status_next      = ST_NO_RUN;
                start_frame_next = '0;
                word_next        = '0;
                state_next       = S_IDLE;
            end
            else
            begin
                word_next  = word_reg + AW'(1);
                ram_raddr  = word_reg + AW'(1);
                state_next = S_SCAN;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            word_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            done_reg  <= done_next;
        end
    end

    // Hold request and search payload
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        start_frame_reg <= start_frame_next;
        cmd_reg         <= cmd_next;
        mark_word_reg   <= mark_word_next;
        mark_bit_reg    <= mark_bit_next;
        len_reg         <= len_next;
        have_reg        <= have_next;
        first_reg       <= first_next;
        byte_reg        <= byte_next;
        data_reg        <= data_next;
        start_reg       <= start_next;
        end_reg         <= end_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign start_frame = start_frame_reg;

    `FBRA_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done)
    `FBRA_ASSERT_IMPLY(a_err_zero_start, done && status != ST_OK, start_frame == 14'd0)
    `FBRA_ASSERT_IMPLY(a_write_busy, ram_we, busy)
    `FBRA_ASSERT_IMPLY(a_rewrite_alloc, state_reg == S_ALLOC_WR, cmd_reg == CMD_ALLOC)

endmodule

FILE: tb/sv/frame_bitmap_run_allocator_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for frame_bitmap_run_allocator_core: bursty request driver,
// result monitor and a bitmap predictor of its own. Depends on fbra_pkg and the RTL.

module frame_bitmap_run_allocator_core_test;

    import fbra_pkg::*;

    localparam int BITMAP_WORDS = 256;
    localparam int FRAMES       = BITMAP_WORDS * WORD_BITS;
    localparam int ITEM_GOAL    = 1100;
    // worst request: mixed-word scan of the whole bitmap plus a full rewrite
    localparam int TAIL_CYCLES  = BITMAP_WORDS * 9 + BITMAP_WORDS + 500;
    localparam int CYCLE_LIMIT  = 16_000_000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [39:0] frame_index;
        logic [14:0] run_length;
        logic        drain_first;
    } frame_request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] start_frame;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  cmd = CMD_FIND;
    logic [39:0] frame_index = '0;
    logic [14:0] run_length = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [13:0] start_frame;

    frame_request_t pending_requests[$];
    frame_result_t  expected_results[$];
    frame_request_t in_flight;
    logic [63:0]    usage_model [BITMAP_WORDS];

    int unsigned n_total = 0;
    int unsigned n_sent = 0;
    int unsigned n_got = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 4;
    int unsigned n_find = 0, n_alloc = 0, n_mark = 0;
    int unsigned n_ok = 0, n_no_run = 0, n_range = 0, n_zero = 0;
    logic        accepted_now;
    logic        launch;

    frame_bitmap_run_allocator_core #(
        .BITMAP_WORDS(BITMAP_WORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .frame_index(frame_index),
        .run_length(run_length),
        .done(done),
        .status(status),
        .start_frame(start_frame)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Lowest run of 'want' free frames; skip wholly used words, and wholly free words that cannot end the run, at once
    function automatic logic first_free_run(input int unsigned want, output int unsigned first);
        int unsigned have;
        int unsigned w;
        int unsigned b;
        have = 0;
        first = 0;
        for (w = 0; w < BITMAP_WORDS; w++)
        begin
            if (usage_model[w] == '1)
                have = 0;
            else if (usage_model[w] == '0 && have + WORD_BITS < want)
            begin
                if (have == 0)
                    first = w * WORD_BITS;
                have += WORD_BITS;
            end
            else
            begin
                for (b = 0; b < WORD_BITS; b++)
                begin
                    if (usage_model[w][b])
                        have = 0;
                    else
                    begin
                        if (have == 0)
                            first = w * WORD_BITS + b;
                        have++;
                        if (have == want)
                            return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // Apply one request to the bitmap copy and work out its result
    function automatic frame_result_t predict_frame_request(input frame_request_t rq);
        frame_result_t r;
        int unsigned   first;
        int unsigned   k;
        int unsigned   f;
        r.status = ST_OK;
        r.start_frame = '0;
        if (rq.cmd == CMD_USED || rq.cmd == CMD_FREE)
        begin
            if ((rq.frame_index >> 6) >= BITMAP_WORDS)
                r.status = ST_RANGE;
            else
            begin
                f = rq.frame_index[31:0];
                usage_model[f / WORD_BITS][f % WORD_BITS] = (rq.cmd == CMD_USED);
            end
        end
        else if (rq.run_length == 0)
            r.status = ST_ZERO;
        else if (!first_free_run(rq.run_length, first))
            r.status = ST_NO_RUN;
        else
        begin
            r.start_frame = first[13:0];
            if (rq.cmd == CMD_ALLOC)
            begin
                for (k = 0; k < rq.run_length; k++)
                    usage_model[(first + k) / WORD_BITS][(first + k) % WORD_BITS] = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic logic [39:0] any_frame();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[39:0];
    endfunction

    task automatic queue_request(input logic [1:0] op, input logic [39:0] frame,
                                 input logic [14:0] len, input logic drain);
        frame_request_t rq;
        rq.cmd = op;
        rq.frame_index = frame;
        rq.run_length = len;
        rq.drain_first = drain;
        pending_requests.push_back(rq);
    endtask

    // Driver: hold a request until taken, then launch the next in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            for (int w = 0; w < BITMAP_WORDS; w++)
                usage_model[w] = '1;
        end
        else
        begin
            launch = 1'b0;
            accepted_now = start && !busy;
            if (accepted_now)
            begin
                expected_results.push_back(predict_frame_request(in_flight));
                n_sent <= n_sent + 1;
                if (in_flight.cmd == CMD_FIND)
                    n_find++;
                else if (in_flight.cmd == CMD_ALLOC)
                    n_alloc++;
                else
                    n_mark++;
            end
            if (!start || accepted_now)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain_first && n_got != n_sent + accepted_now))
                    launch = 1'b1;
            end
            if (launch)
            begin
                in_flight = pending_requests.pop_front();
                start <= 1'b1;
                cmd <= in_flight.cmd;
                frame_index <= in_flight.frame_index;
                run_length <= in_flight.run_length;
                burst_left--;
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(10, 40);
                        gap_left = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(1, 20);
                    end
                end
            end
            else if (accepted_now)
                start <= 1'b0;
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                if (status !== expected_results[0].status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, expected_results[0].status));
                if (start_frame !== expected_results[0].start_frame)
                    report_mismatch($sformatf("start_frame %0d, expected %0d",
                                              start_frame, expected_results[0].start_frame));
                void'(expected_results.pop_front());
            end
            case (status)
                ST_OK:     n_ok++;
                ST_NO_RUN: n_no_run++;
                ST_RANGE:  n_range++;
                default:   n_zero++;
            endcase
            n_got <= n_got + 1;
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, n_total - n_got);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned base;
        int unsigned span;
        int unsigned k;
        int unsigned n;
        int unsigned r;
        logic [39:0] far;

        // Directed: full bitmap, zero lengths, edges of the range, a run across words
        queue_request(CMD_FIND, any_frame(), 15'd1, 1'b0);
        queue_request(CMD_ALLOC, any_frame(), 15'd0, 1'b0);
        queue_request(CMD_FIND, any_frame(), 15'd0, 1'b0);
        queue_request(CMD_FREE, 40'd0, 15'h7FFF, 1'b0);
        queue_request(CMD_FREE, 40'(FRAMES - 1), 15'd0, 1'b0);
        queue_request(CMD_USED, 40'(FRAMES), 15'd3, 1'b0);
        queue_request(CMD_FREE, 40'hFF_FFFF_FFFF, 15'd1, 1'b0);
        queue_request(CMD_USED, 40'h80_0000_0003, 15'd1, 1'b0);
        queue_request(CMD_FIND, 40'hFF_FFFF_FFFF, 15'd1, 1'b0);
        queue_request(CMD_ALLOC, 40'd0, 15'd1, 1'b0);
        queue_request(CMD_FIND, 40'd0, 15'd1, 1'b0);
        queue_request(CMD_ALLOC, 40'd0, 15'd1, 1'b0);
        queue_request(CMD_FIND, 40'd0, 15'd1, 1'b0);
        queue_request(CMD_FREE, 40'd62, 15'd0, 1'b0);
        queue_request(CMD_FREE, 40'd63, 15'd0, 1'b0);
        queue_request(CMD_FREE, 40'd64, 15'd0, 1'b0);
        queue_request(CMD_FREE, 40'd65, 15'd0, 1'b0);
        queue_request(CMD_FIND, 40'd0, 15'd4, 1'b0);
        queue_request(CMD_ALLOC, 40'd0, 15'd4, 1'b0);
        queue_request(CMD_FIND, 40'd0, 15'h7FFF, 1'b0);
        queue_request(CMD_ALLOC, 40'd0, 15'd16384, 1'b0);
        queue_request(CMD_USED, 40'd5, 15'd0, 1'b0);
        queue_request(CMD_FREE, 40'd7, 15'd0, 1'b0);
        queue_request(CMD_FREE, 40'd7, 15'd0, 1'b0);

        // Random: mostly free regions followed by finds and allocations, plus noise
        while (pending_requests.size() < ITEM_GOAL)
        begin
            r = $urandom_range(0, 99);
            if (pending_requests.size() > 0 && $urandom_range(0, 19) == 0)
                queue_request(CMD_FIND, any_frame(), 15'($urandom_range(1, 8)), 1'b1);
            if (r < 35)
            begin
                // free a region, now and then leaving a used frame inside it
                if ($urandom_range(0, 3) == 0)
                    base = $urandom_range(0, BITMAP_WORDS - 1) * WORD_BITS + $urandom_range(48, 63);
                else
                    base = $urandom_range(0, FRAMES - 1);
                span = $urandom_range(4, 40);
                for (k = 0; k < span; k++)
                begin
                    if (base + k < FRAMES)
                        queue_request(($urandom_range(0, 9) == 0) ? CMD_USED : CMD_FREE,
                                      40'(base + k), 15'($urandom_range(0, 32767)), 1'b0);
                end
            end
            else if (r < 65)
            begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    queue_request(($urandom_range(0, 4) < 3) ? CMD_ALLOC : CMD_FIND, any_frame(),
                                  15'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 64)
                                                                  : $urandom_range(1, 8)), 1'b0);
            end
            else if (r < 80)
                queue_request($urandom_range(0, 1) ? CMD_USED : CMD_FREE,
                              40'($urandom_range(0, FRAMES - 1)),
                              15'($urandom_range(0, 32767)), 1'b0);
            else if (r < 92)
            begin
                far = any_frame();
                if (far < FRAMES)
                    far = far + 40'(FRAMES);
                if ($urandom_range(0, 1))
                    queue_request($urandom_range(0, 1) ? CMD_USED : CMD_FREE, far,
                                  15'($urandom_range(0, 32767)), 1'b0);
                else
                    queue_request($urandom_range(0, 1) ? CMD_ALLOC : CMD_FIND, far, 15'd0, 1'b0);
            end
            else
                queue_request($urandom_range(0, 1) ? CMD_ALLOC : CMD_FIND, any_frame(),
                              15'($urandom_range(65, 32767)), 1'b0);
        end
        n_total = pending_requests.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Hold until every request has its result, then watch for strays
        while (n_got != n_total)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d requests: %0d finds, %0d allocations, %0d frame marks",
                 n_total, n_find, n_alloc, n_mark);
        $display("results: %0d ok, %0d no run, %0d out of range, %0d zero length; %0d mismatches",
                 n_ok, n_no_run, n_range, n_zero, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: frame_bitmap_run_allocator_core.f
+incdir+hw/rtl
hw/rtl/fbra_pkg.sv
hw/rtl/fbra_ram.sv
hw/rtl/frame_bitmap_run_allocator_core.sv
tb/sv/frame_bitmap_run_allocator_core_test.sv
